### rtl/timed_banner_queue_assert.svh
// ----------------------------------------------------------------------------
// Timed banner queue assertion macros
// Shared property forms for the checker of the banner queue.
// ----------------------------------------------------------------------------
`ifndef TIMED_BANNER_QUEUE_ASSERT_SVH
`define TIMED_BANNER_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define TBQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("banner queue check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define TBQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("banner queue check failed");

`endif

### rtl/tbq_pkg.sv
// ----------------------------------------------------------------------------
// Timed banner queue package
// Word types of the request and response channels and the code values.
// ----------------------------------------------------------------------------
`default_nettype none

package tbq_pkg;

   localparam logic       OP_POST   = 1'b0;
   localparam logic       OP_TICK   = 1'b1;

   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_SHOW  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [15:0] message_tag;
      logic [31:0] dwell_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] shown_tag;
      logic        dropped;
      logic [2:0]  pending_count;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/tbq_ram.sv
// ----------------------------------------------------------------------------
// Timed banner queue RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tbq_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 5
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/timed_banner_queue.sv
// ----------------------------------------------------------------------------
// Timed banner queue
// Each request word either posts a banner (tag and dwell in milliseconds,
// zero dwell meaning it stays until replaced) or is a one millisecond tick;
// every request yields exactly one response word telling whether to show a
// banner, clear it, or change nothing. Waiting posts sit in a ring held in a
// RAM. A request is captured in the idle state; in the exec state the head
// entry of the ring arrives from the RAM's registered read port and the
// response is registered. The next request is taken only back in idle, so
// no request is taken before the last is through; the block waits longer
// while the response side stalls. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_banner_queue #(
   parameter int RING_DEPTH = 5,
   parameter int TAG_BITS   = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire tbq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output tbq_pkg::rsp_type      rsp_data
);

   import tbq_pkg::*;

   localparam int PTR_BITS   = $clog2(RING_DEPTH);
   localparam int CNT_BITS   = $clog2(RING_DEPTH + 1);
   localparam int ENTRY_BITS = TAG_BITS + 32;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type               state_ff, state_in;
   req_type                 item_ff, item_in;
   logic [PTR_BITS-1:0]     read_slot_ff, read_slot_in;
   logic [PTR_BITS-1:0]     write_slot_ff, write_slot_in;
   logic [CNT_BITS-1:0]     waiting_ff, waiting_in;
   logic                    banner_on_ff, banner_on_in;
   logic [31:0]             banner_dwell_ff, banner_dwell_in;
   logic [31:0]             elapsed_ff, elapsed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    exec_go;
   logic                    wr_en;
   logic [ENTRY_BITS-1:0]   wr_data;
   logic [ENTRY_BITS-1:0]   rd_data;

   function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] s);
      next_slot = (s == PTR_BITS'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   tbq_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (write_slot_ff),
      .wr_data (wr_data),
      .rd_addr (read_slot_ff),
      .rd_data (rd_data)
   );

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign exec_go   = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);
   assign item_in   = accept ? req_data : item_ff;

   always_comb begin
      logic [TAG_BITS-1:0] tag;
      logic [TAG_BITS-1:0] shown;
      logic [31:0]         elapsed_inc;
      logic                full;
      logic                push;
      logic                pop;
      logic                drop;
      logic [1:0]          action;

      tag         = TAG_BITS'(item_ff.message_tag);
      shown       = '0;
      elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
      full        = (waiting_ff == CNT_BITS'(RING_DEPTH));
      push        = 1'b0;
      pop         = 1'b0;
      drop        = 1'b0;
      action      = ACT_NONE;

      state_in        = state_ff;
      read_slot_in    = read_slot_ff;
      write_slot_in   = write_slot_ff;
      waiting_in      = waiting_ff;
      banner_on_in    = banner_on_ff;
      banner_dwell_in = banner_dwell_ff;
      elapsed_in      = elapsed_ff;
      wr_en           = 1'b0;
      wr_data         = {tag, item_ff.dwell_ms};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (exec_go) begin
         if (item_ff.operation == OP_POST) begin
            if (!banner_on_ff) begin
               banner_on_in    = 1'b1;
               banner_dwell_in = item_ff.dwell_ms;
               elapsed_in      = '0;
               action          = ACT_SHOW;
               shown           = tag;
            end else if (banner_dwell_ff == '0) begin
               if (waiting_ff == '0) begin
                  banner_dwell_in = item_ff.dwell_ms;
                  elapsed_in      = '0;
                  action          = ACT_SHOW;
                  shown           = tag;
               end else begin
                  push = 1'b1;
                  pop  = 1'b1;
               end
            end else begin
               push = 1'b1;
            end
         end else if (banner_on_ff && (banner_dwell_ff != '0)) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= banner_dwell_ff) begin
               if (waiting_ff != '0) begin
                  pop = 1'b1;
               end else begin
                  banner_on_in    = 1'b0;
                  banner_dwell_in = '0;
                  elapsed_in      = '0;
                  action          = ACT_CLEAR;
               end
            end
         end

         if (push) begin
            if (full) begin
               drop = 1'b1;
            end else begin
               wr_en         = 1'b1;
               write_slot_in = next_slot(write_slot_ff);
            end
         end

         if (pop) begin
            shown           = rd_data[ENTRY_BITS-1:32];
            banner_dwell_in = rd_data[31:0];
            read_slot_in    = next_slot(read_slot_ff);
            banner_on_in    = 1'b1;
            elapsed_in      = '0;
            action          = ACT_SHOW;
         end

         waiting_in = waiting_ff + CNT_BITS'(wr_en) - CNT_BITS'(pop);
      end

      rsp_data_in.action        = action;
      rsp_data_in.shown_tag     = 16'(shown);
      rsp_data_in.dropped       = drop;
      rsp_data_in.pending_count = 3'(waiting_in);
      if (!exec_go) begin
         rsp_data_in = rsp_data_ff;
      end

      rsp_valid_in = exec_go || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         read_slot_ff    <= '0;
         write_slot_ff   <= '0;
         waiting_ff      <= '0;
         banner_on_ff    <= 1'b0;
         banner_dwell_ff <= '0;
         elapsed_ff      <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         read_slot_ff    <= read_slot_in;
         write_slot_ff   <= write_slot_in;
         waiting_ff      <= waiting_in;
         banner_on_ff    <= banner_on_in;
         banner_dwell_ff <= banner_dwell_in;
         elapsed_ff      <= elapsed_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/tbq_check.sv
// ----------------------------------------------------------------------------
// Timed banner queue checker
// Port-level checks of the banner queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timed_banner_queue_assert.svh"

module tbq_check #(
   parameter int RING_DEPTH = 5
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_stall,
   input wire logic             rsp_valid,
   input wire logic             rsp_stall,
   input wire tbq_pkg::rsp_type rsp_data
);

   import tbq_pkg::*;

   logic drop_fits;

   // A dropped post leaves the ring full, unless an endless banner also pops its head.
   assign drop_fits = (rsp_data.pending_count == 3'(RING_DEPTH))
      || ((rsp_data.action == ACT_SHOW) && (rsp_data.pending_count == 3'(RING_DEPTH - 1)));

   `TBQ_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   `TBQ_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   `TBQ_ASSERT_IMP(a_clear_empty, clock, reset, rsp_valid && (rsp_data.action == ACT_CLEAR), (rsp_data.pending_count == 3'd0) && !rsp_data.dropped)

   `TBQ_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid && rsp_data.dropped, drop_fits)

endmodule

bind timed_banner_queue tbq_check #(
   .RING_DEPTH (RING_DEPTH)
) u_tbq_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire

### tb/tb.sv
// ----------------------------------------------------------------------------
// Timed banner queue testbench
// Drives posts and millisecond ticks into the banner queue with random gaps
// and response stalls, and with one long response hold-off that backs the
// block up. A scoreboard keeps its own copy of the banner, the dwell counter
// and the waiting ring, predicts one response word per request word, and
// compares every response field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import tbq_pkg::*;

   localparam int RING_SLOTS   = 5;
   localparam int TOTAL_WORDS  = 1850;
   localparam int QUIET_FROM   = 700;
   localparam int QUIET_TO     = 1000;
   localparam int HOLD_AT      = 1300;
   localparam int HOLD_CYCLES  = 200;

   class banner_scoreboard;
      logic [15:0] slot_tag [RING_SLOTS];
      logic [31:0] slot_dwell [RING_SLOTS];
      int unsigned head = 0, tail = 0, count = 0;
      bit          banner_up = 0;
      logic [31:0] shown_dwell = '0;
      logic [31:0] elapsed = '0;
      rsp_type     expected_q[$];
      int          errors = 0, checked = 0;
      int          posts = 0, ticks = 0, drops = 0, shows = 0, clears = 0;

      function bit push_tail(logic [15:0] tag, logic [31:0] dwell);
         if (count >= RING_SLOTS) return 1'b0;
         slot_tag[tail] = tag;
         slot_dwell[tail] = dwell;
         tail = (tail + 1) % RING_SLOTS;
         count++;
         return 1'b1;
      endfunction

      function logic [15:0] pop_head();
         logic [15:0] tag;
         tag = slot_tag[head];
         shown_dwell = slot_dwell[head];
         head = (head + 1) % RING_SLOTS;
         count--;
         banner_up = 1'b1;
         elapsed = '0;
         return tag;
      endfunction

      function bit ring_full_timed();
         return count == RING_SLOTS && banner_up && shown_dwell != 0;
      endfunction

      function int outstanding();
         return expected_q.size();
      endfunction

      function void note_request(req_type word);
         rsp_type r;
         r = '0;
         r.action = ACT_NONE;
         if (word.operation == OP_POST) begin
            posts++;
            if (!banner_up || (shown_dwell == 0 && count == 0)) begin
               banner_up = 1'b1;
               shown_dwell = word.dwell_ms;
               elapsed = '0;
               r.action = ACT_SHOW;
               r.shown_tag = word.message_tag;
            end else if (shown_dwell == 0) begin
               r.dropped = !push_tail(word.message_tag, word.dwell_ms);
               r.shown_tag = pop_head();
               r.action = ACT_SHOW;
            end else begin
               r.dropped = !push_tail(word.message_tag, word.dwell_ms);
            end
         end else begin
            ticks++;
            if (banner_up && shown_dwell != 0) begin
               if (elapsed != '1) elapsed++;
               if (elapsed >= shown_dwell) begin
                  if (count > 0) begin
                     r.shown_tag = pop_head();
                     r.action = ACT_SHOW;
                  end else begin
                     banner_up = 1'b0;
                     shown_dwell = '0;
                     elapsed = '0;
                     r.action = ACT_CLEAR;
                  end
               end
            end
         end
         r.pending_count = 3'(count);
         drops += r.dropped;
         shows += (r.action == ACT_SHOW);
         clears += (r.action == ACT_CLEAR);
         expected_q.push_back(r);
      endfunction

      function void compare_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response word with nothing expected, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         compare_field("action", want.action, got.action);
         compare_field("shown_tag", want.shown_tag, got.shown_tag);
         compare_field("dropped", want.dropped, got.dropped);
         compare_field("pending_count", want.pending_count, got.pending_count);
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   banner_scoreboard book = new();
   int sent = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;

   timed_banner_queue uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic offer_word(input logic op, input logic [15:0] tag, input logic [31:0] dwell);
      req_type word;
      word.operation = op;
      word.message_tag = tag;
      word.dwell_ms = dwell;
      if (sent < QUIET_FROM || sent >= QUIET_TO) begin
         while ($urandom_range(99) < 19) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_request(word);
      sent++;
   endtask

   // Dwell values that would freeze the banner for good are only sent when
   // the ring is full, so the post is dropped but still exercises every bit.
   task automatic offer_random();
      logic [15:0] tag;
      logic [31:0] dwell;
      int pick;
      tag = 16'($urandom);
      dwell = $urandom;
      pick = $urandom_range(99);
      if (book.ring_full_timed()) begin
         offer_word(pick < 50 ? OP_POST : OP_TICK, tag, dwell);
      end else if (pick < 40) begin
         pick = $urandom_range(99);
         if (pick < 20) dwell = '0;
         else if (pick < 95) dwell = $urandom_range(6, 1);
         else dwell = $urandom_range(16, 7);
         offer_word(OP_POST, tag, dwell);
      end else begin
         offer_word(OP_TICK, tag, dwell);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_response(rsp_data);
      if (book.checked == HOLD_AT && !hold_done) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (book.checked >= QUIET_FROM && book.checked < QUIET_TO) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 19);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      offer_word(OP_POST, 16'h0000, 32'h0000_0000);
      offer_word(OP_TICK, 16'hFFFF, 32'hFFFF_FFFF);
      offer_word(OP_POST, 16'hFFFF, 32'h0000_0003);
      offer_word(OP_POST, 16'h1234, 32'h0000_0000);
      offer_word(OP_POST, 16'hA5A5, 32'h0000_0001);
      offer_word(OP_POST, 16'h5A5A, 32'h0000_0002);
      offer_word(OP_POST, 16'h0001, 32'h0000_0001);
      offer_word(OP_POST, 16'h8000, 32'h0000_0001);
      offer_word(OP_POST, 16'hFFFF, 32'hFFFF_FFFF);
      offer_word(OP_POST, 16'h7FFF, 32'hAAAA_AAAA);
      offer_word(OP_POST, 16'h0F0F, 32'h5555_5555);
      repeat (3) offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      offer_word(OP_POST, 16'h00FF, 32'h0000_0004);
      repeat (5) offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      repeat (4) offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      offer_word(OP_POST, 16'hC3C3, 32'h0000_0001);
      offer_word(OP_TICK, 16'h0000, 32'h0000_0000);
      while (sent < TOTAL_WORDS) offer_random();
      req_valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d words: %0d posts with %0d dropped, and %0d ticks.",
               sent, book.posts, book.drops, book.ticks);
      $display("Checked %0d responses, %0d showing a banner and %0d clearing it.",
               book.checked, book.shows, book.clears);
      if (book.errors == 0 && book.outstanding() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Run timed out with %0d words sent.", sent);
      $display("tb NOT OK");
      $finish;
   end

endmodule
